FILE: rtl/rbpl_pkg.sv
// Shared types, constants and helpers for the run/block prescale lookup.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rbpl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH   = 256;
  localparam int TABLE_COUNT   = 5;
  localparam int TOTAL_ENTRIES = TABLE_COUNT * TABLE_DEPTH;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int TSEL_W = 3;
  localparam int RUN_W  = 20;
  localparam int BLK_W  = 16;
  localparam int PS_W   = 24;

  // Derived widths
  localparam int ADDR_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int TAB_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;

  // Weight returned when nothing matches or lookup is off
  localparam logic [PS_W-1:0] WEIGHT_ONE = PS_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // One stored table entry
  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic [BLK_W-1:0] start;
    logic [PS_W-1:0]  prescale;
  } entry_t;

  // Request from the sequencer to the entry memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Outcome of the shared compare unit for one entry
  typedef struct packed {
    logic base_hit;
    logic extend;
  } match_t;

  // First memory address of a table
  function automatic logic [ADDR_W-1:0] table_base(input logic [TAB_W-1:0] tab);
    table_base = ADDR_W'(tab) * ADDR_W'(TABLE_DEPTH);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rbpl_entry_mem.sv
// Entry memory for all tables: one write port, one registered read port.
// Depends on rbpl_pkg for the entry type and address width.
`default_nettype none

module rbpl_entry_mem import rbpl_pkg::*; (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output entry_t        rd_data_o
);

  entry_t mem_q [TOTAL_ENTRIES];
  entry_t rd_data_q;

  // Write one entry, read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/rbpl_match.sv
// Shared compare unit: tests one entry against the query run and block.
// Depends on rbpl_pkg for the entry and match types.
`default_nettype none

module rbpl_match import rbpl_pkg::*; (
  input  wire entry_t           ent_i,
  input  wire logic [RUN_W-1:0] run_i,
  input  wire logic [BLK_W-1:0] blk_i,
  input  wire logic [BLK_W-1:0] first_start_i,
  output match_t                res_o
);

  // Same run and a start at or below the block
  assign res_o.base_hit = (ent_i.run == run_i) && (ent_i.start <= blk_i);
  // Advance only past the start of the first match
  assign res_o.extend   = res_o.base_hit && (ent_i.start > first_start_i);

endmodule

`default_nettype wire

FILE: rtl/rbpl_seq.sv
// Sequencer: entry counts, append/clear handling and the one-entry-a-cycle
// table scan. Depends on rbpl_pkg and instantiates rbpl_match.
`default_nettype none

module rbpl_seq import rbpl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [TSEL_W-1:0] table_select_i,
  input  wire logic [RUN_W-1:0]  run_number_i,
  input  wire logic [BLK_W-1:0]  block_number_i,
  input  wire logic [PS_W-1:0]   prescale_value_i,
  input  wire logic              lookup_en_i,
  input  wire entry_t            rd_data_i,
  output mem_req_t               mem_req_o,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output logic [PS_W-1:0]        weight_o,
  output logic                   matched_o,
  output logic                   table_full_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN
  } state_e;

  state_e            state_q;
  logic              found_q;
  logic [IDX_W-1:0]  ptr_q;
  logic              res_valid_q;
  logic [PS_W-1:0]   weight_q;
  logic              matched_q;
  logic              full_q;

  logic [TAB_W-1:0]  tab_q;
  logic [RUN_W-1:0]  run_q;
  logic [BLK_W-1:0]  blk_q;
  logic [CNT_W-1:0]  n_q;
  logic [BLK_W-1:0]  first_q;
  logic [PS_W-1:0]   ps_q;

  logic [CNT_W-1:0]  cnt_q [TABLE_COUNT];

  logic              accept;
  logic              tab_ok;
  logic [TAB_W-1:0]  tab_in;
  logic [CNT_W-1:0]  cur_cnt;
  logic              wr_ok;
  logic [IDX_W-1:0]  ptr_rd;
  logic              last;
  logic              take;
  logic              stop;
  cmd_e              cmd;
  match_t            hit;

  assign accept  = start && (state_q == S_IDLE);
  assign busy_o  = (state_q != S_IDLE);
  assign cmd     = cmd_e'(command_i);
  assign tab_ok  = 32'(table_select_i) < TABLE_COUNT;
  assign tab_in  = TAB_W'(table_select_i);
  assign cur_cnt = tab_ok ? cnt_q[tab_in] : '0;
  assign wr_ok   = tab_ok && (cur_cnt < CNT_W'(TABLE_DEPTH));

  // Memory port: write on an append transfer to a table with room, read ahead of the check
  assign ptr_rd            = (state_q == S_SCAN) ? ptr_q + IDX_W'(1) : ptr_q;
  assign mem_req_o.we      = accept && (cmd == CMD_APPEND) && wr_ok;
  assign mem_req_o.waddr   = table_base(tab_in) + ADDR_W'(cur_cnt);
  assign mem_req_o.wdata   = '{run: run_number_i, start: block_number_i,
                               prescale: prescale_value_i};
  assign mem_req_o.raddr   = table_base(tab_q) + ADDR_W'(ptr_rd);

  rbpl_match u_match (
    .ent_i         (rd_data_i),
    .run_i         (run_q),
    .blk_i         (blk_q),
    .first_start_i (first_q),
    .res_o         (hit)
  );

  // Scan decisions for the entry now on the read port
  assign last = (CNT_W'(ptr_q) + CNT_W'(1)) == n_q;
  assign take = found_q ? hit.extend : hit.base_hit;
  assign stop = (found_q && !hit.extend) || last;

  // Sequencer state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      found_q     <= 1'b0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
      weight_q    <= '0;
      matched_q   <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_APPEND: begin
                res_valid_q <= 1'b1;
                weight_q    <= '0;
                matched_q   <= 1'b0;
                full_q      <= !wr_ok;
              end
              CMD_QUERY: begin
                if (lookup_en_i && tab_ok && (cur_cnt != '0)) begin
                  state_q <= S_FIRST;
                  ptr_q   <= '0;
                  found_q <= 1'b0;
                end else begin
                  res_valid_q <= 1'b1;
                  weight_q    <= WEIGHT_ONE;
                  matched_q   <= 1'b0;
                  full_q      <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_FIRST: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          ptr_q <= ptr_q + IDX_W'(1);
          if (take) begin
            found_q <= 1'b1;
          end
          if (stop) begin
            state_q     <= S_IDLE;
            res_valid_q <= 1'b1;
            matched_q   <= found_q || take;
            full_q      <= 1'b0;
            if (take) begin
              weight_q <= rd_data_i.prescale;
            end else if (found_q) begin
              weight_q <= ps_q;
            end else begin
              weight_q <= WEIGHT_ONE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the query and the running choice
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tab_q <= tab_in;
      run_q <= run_number_i;
      blk_q <= block_number_i;
      n_q   <= cur_cnt;
    end
    if ((state_q == S_SCAN) && take) begin
      ps_q <= rd_data_i.prescale;
      if (!found_q) begin
        first_q <= rd_data_i.start;
      end
    end
  end

  // Entry counts: advance on append, drop to zero on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TABLE_COUNT; t++) begin
        cnt_q[t] <= '0;
      end
    end else if (accept && tab_ok) begin
      if ((cmd == CMD_APPEND) && wr_ok) begin
        cnt_q[tab_in] <= cur_cnt + CNT_W'(1);
      end else if (cmd == CMD_CLEAR) begin
        cnt_q[tab_in] <= '0;
      end
    end
  end

  assign res_valid_o  = res_valid_q;
  assign weight_o     = weight_q;
  assign matched_o    = matched_q;
  assign table_full_o = full_q;

endmodule

`default_nettype wire

FILE: rtl/run_block_prescale_lookup.sv
// Top level of the run/block prescale lookup: lookup enable register,
// sequencer and entry memory. Depends on rbpl_pkg, rbpl_seq, rbpl_entry_mem.
//
//   Channel   Handshake                        Payload
//   input     start high, busy low             command, table_select, run_number,
//                                              block_number, prescale_value
//   result    result_valid_o (one cycle)       weight, matched, table_full
//   config    lookup_enable_we_i               lookup_enable_i
//
// An append, or a query that needs no scan, gives its result in the cycle after
// the transfer and busy stays low. A scanned query keeps busy high while it
// runs: a first state primes the registered read port, then one entry is
// checked a cycle until the advance ends or the table's entries (at most
// TABLE_DEPTH) do. The result shows in the first cycle with busy low. A clear
// gives no result and busy stays low; the receiver cannot stall the results.
// Reset is asynchronous and active low; it empties every table at once and
// turns lookup off.
`default_nettype none

module run_block_prescale_lookup import rbpl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [TSEL_W-1:0] table_select_i,
  input  wire logic [RUN_W-1:0]  run_number_i,
  input  wire logic [BLK_W-1:0]  block_number_i,
  input  wire logic [PS_W-1:0]   prescale_value_i,
  output logic                   result_valid_o,
  output logic [PS_W-1:0]        weight_o,
  output logic                   matched_o,
  output logic                   table_full_o,
  input  wire logic              lookup_enable_we_i,
  input  wire logic              lookup_enable_i
);

  logic     lookup_en_q;
  mem_req_t mem_req;
  entry_t   rd_data;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookup_en_q <= 1'b0;
    end else if (lookup_enable_we_i) begin
      lookup_en_q <= lookup_enable_i;
    end
  end

  rbpl_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .command_i        (command_i),
    .table_select_i   (table_select_i),
    .run_number_i     (run_number_i),
    .block_number_i   (block_number_i),
    .prescale_value_i (prescale_value_i),
    .lookup_en_i      (lookup_en_q),
    .rd_data_i        (rd_data),
    .mem_req_o        (mem_req),
    .busy_o           (busy),
    .res_valid_o      (result_valid_o),
    .weight_o         (weight_o),
    .matched_o        (matched_o),
    .table_full_o     (table_full_o)
  );

  rbpl_entry_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

`default_nettype wire

FILE: rtl/rbpl_checker.sv
// Port-level checks for the run/block prescale lookup, bound to the top level.
// Depends on rbpl_pkg and run_block_prescale_lookup.
`default_nettype none

module rbpl_checker import rbpl_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [CMD_W-1:0]  command_i,
  input wire logic              result_valid_o,
  input wire logic [PS_W-1:0]   weight_o,
  input wire logic              matched_o,
  input wire logic              table_full_o
);

  logic xfer;
  assign xfer = start && !busy;

  // An append transfer gives its result in the next cycle
  a_append_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (command_i == CMD_APPEND)
      |=> result_valid_o && (weight_o == '0) && !matched_o)
    else $error("append transfer without its result");

  // Clear and unused commands give no result
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (command_i != CMD_APPEND) && (command_i != CMD_QUERY)
      |=> !result_valid_o)
    else $error("result after a command that gives none");

  // A match and a dropped append never share a result
  a_match_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && matched_o |-> !table_full_o)
    else $error("matched result flagged as table full");

  // A dropped append carries weight zero
  a_full_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && table_full_o |-> (weight_o == '0))
    else $error("table full result with non-zero weight");

  // A query without a match reports weight one
  a_miss_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !matched_o && !table_full_o && (weight_o != '0)
      |-> (weight_o == WEIGHT_ONE))
    else $error("unmatched query with weight other than one");

endmodule

bind run_block_prescale_lookup rbpl_checker u_rbpl_checker (.*);

`default_nettype wire

FILE: tb/run_block_prescale_lookup_tb.sv
// Self-checking testbench for run_block_prescale_lookup: random and directed table
// traffic, with a prescale ledger class that predicts every weight result.
// Depends on rbpl_pkg and the run_block_prescale_lookup RTL only.
`timescale 1ns / 100ps

module run_block_prescale_lookup_tb;
  import rbpl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 8 * (TABLE_DEPTH + 24);
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int FULL_TABLE = 3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TSEL_W-1:0] tsel;
    logic [RUN_W-1:0]  run;
    logic [BLK_W-1:0]  blk;
    logic [PS_W-1:0]   ps;
  } item_t;

  typedef struct packed {
    logic [PS_W-1:0] weight;
    logic            matched;
    logic            full;
  } outcome_t;

  // Mirror of the tables plus the queue of weights still owed by the block
  class weight_ledger;
    logic [RUN_W-1:0] run_tab   [TABLE_COUNT][TABLE_DEPTH];
    logic [BLK_W-1:0] start_tab [TABLE_COUNT][TABLE_DEPTH];
    logic [PS_W-1:0]  ps_tab    [TABLE_COUNT][TABLE_DEPTH];
    int               fill      [TABLE_COUNT];
    bit               enabled;
    outcome_t         pending[$];
    int errors, results, appends, drops, queries, hits;

    // First entry matching run and block, then advance along later starts
    function outcome_t predict_weight(item_t it);
      outcome_t o;
      int t, i, j;
      o.weight  = WEIGHT_ONE;
      o.matched = 1'b0;
      o.full    = 1'b0;
      if (!enabled || it.tsel >= TABLE_COUNT) return o;
      t = it.tsel;
      for (i = 0; i < fill[t]; i++) begin
        if (run_tab[t][i] == it.run && it.blk >= start_tab[t][i]) begin
          j = i;
          while (j + 1 < fill[t] && run_tab[t][j+1] == it.run &&
                 it.blk >= start_tab[t][j+1] && start_tab[t][j+1] > start_tab[t][i])
            j++;
          o.weight  = ps_tab[t][j];
          o.matched = 1'b1;
          return o;
        end
      end
      return o;
    endfunction

    // Apply one accepted transfer and queue the result it owes
    function void note_item(item_t it);
      outcome_t o;
      int t;
      o = '0;
      t = it.tsel;
      case (it.cmd)
        CMD_APPEND: begin
          appends++;
          if (t >= TABLE_COUNT || fill[t] >= TABLE_DEPTH) begin
            o.full = 1'b1;
            drops++;
          end else begin
            run_tab[t][fill[t]]   = it.run;
            start_tab[t][fill[t]] = it.blk;
            ps_tab[t][fill[t]]    = it.ps;
            fill[t]++;
          end
          pending.push_back(o);
        end
        CMD_QUERY: begin
          queries++;
          o = predict_weight(it);
          if (o.matched) hits++;
          pending.push_back(o);
        end
        CMD_CLEAR: begin
          if (t < TABLE_COUNT) fill[t] = 0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one result against the oldest prediction
    task check_weight(logic [PS_W-1:0] w, logic m, logic f);
      outcome_t o;
      results++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, weight %0d", w));
        return;
      end
      o = pending.pop_front();
      if (w !== o.weight)
        report_mismatch($sformatf("weight %0d, predicted %0d", w, o.weight));
      if (m !== o.matched)
        report_mismatch($sformatf("matched %b, predicted %b", m, o.matched));
      if (f !== o.full)
        report_mismatch($sformatf("table_full %b, predicted %b", f, o.full));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  command_i = '0;
  logic [TSEL_W-1:0] table_select_i = '0;
  logic [RUN_W-1:0]  run_number_i = '0;
  logic [BLK_W-1:0]  block_number_i = '0;
  logic [PS_W-1:0]   prescale_value_i = '0;
  logic              result_valid_o;
  logic [PS_W-1:0]   weight_o;
  logic              matched_o;
  logic              table_full_o;
  logic              lookup_enable_we_i = 1'b0;
  logic              lookup_enable_i = 1'b0;

  weight_ledger ledger = new;
  int burst_left = 0;
  int sent_count = 0;
  int idle_cycles = 0;

  run_block_prescale_lookup i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .table_select_i    (table_select_i),
    .run_number_i      (run_number_i),
    .block_number_i    (block_number_i),
    .prescale_value_i  (prescale_value_i),
    .result_valid_o    (result_valid_o),
    .weight_o          (weight_o),
    .matched_o         (matched_o),
    .table_full_o      (table_full_o),
    .lookup_enable_we_i(lookup_enable_we_i),
    .lookup_enable_i   (lookup_enable_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Observe transfers and results at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        ledger.note_item('{command_i, table_select_i, run_number_i, block_number_i,
                           prescale_value_i});
      if (result_valid_o)
        ledger.check_weight(weight_o, matched_o, table_full_o);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic item_t mk(logic [CMD_W-1:0] cmd, logic [TSEL_W-1:0] tsel,
                               logic [RUN_W-1:0] run, logic [BLK_W-1:0] blk,
                               logic [PS_W-1:0] ps);
    item_t it;
    it.cmd  = cmd;
    it.tsel = tsel;
    it.run  = run;
    it.blk  = blk;
    it.ps   = ps;
    return it;
  endfunction

  // Sender gap: mostly random, with bursts of back-to-back items
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Few runs so that queries hit; the odd wide value exercises every bit
  function automatic logic [RUN_W-1:0] pick_run();
    case ($urandom_range(0, 9))
      0: return RUN_W'($urandom);
      1: return '1;
      default: return RUN_W'(1000 + $urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [BLK_W-1:0] pick_blk();
    case ($urandom_range(0, 9))
      0: return BLK_W'($urandom);
      1: return BLK_W'(16'hFFFF - $urandom_range(0, 15));
      default: return BLK_W'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [PS_W-1:0] pick_ps();
    return ($urandom_range(0, 19) == 0) ? '0 : PS_W'($urandom);
  endfunction

  function automatic logic [TSEL_W-1:0] pick_tsel();
    if ($urandom_range(0, 19) == 0) return TSEL_W'($urandom_range(TABLE_COUNT, 7));
    return TSEL_W'($urandom_range(0, TABLE_COUNT - 1));
  endfunction

  function automatic item_t random_item();
    int r;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 40) cmd = CMD_APPEND;
    else if (r < 85) cmd = CMD_QUERY;
    else if (r < 95) cmd = CMD_CLEAR;
    else cmd = CMD_SPARE;
    return mk(cmd, pick_tsel(), pick_run(), pick_blk(), pick_ps());
  endfunction

  // Hold the item on the bus until the block takes it
  task automatic send_item(item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i        <= it.cmd;
    table_select_i   <= it.tsel;
    run_number_i     <= it.run;
    block_number_i   <= it.blk;
    prescale_value_i <= it.ps;
    start            <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (it.cmd == CMD_APPEND || it.cmd == CMD_QUERY) sent_count++;
  endtask

  // Stop sending and wait until every owed result has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_lookup(bit on);
    lookup_enable_i    <= on;
    lookup_enable_we_i <= 1'b1;
    @(posedge clk_i);
    lookup_enable_we_i <= 1'b0;
    ledger.enabled = on;
  endtask

  // One run's entries appended to a table, then queried around their starts
  task automatic send_chain();
    int t, k;
    logic [RUN_W-1:0] r;
    logic [BLK_W-1:0] b0, b;
    t  = $urandom_range(0, TABLE_COUNT - 1);
    r  = pick_run();
    b0 = BLK_W'($urandom_range(0, 40));
    if ($urandom_range(0, 2) == 0) send_item(mk(CMD_CLEAR, TSEL_W'(t), '0, '0, '0));
    k = $urandom_range(1, 6);
    repeat (k) begin
      b = BLK_W'(b0 + $urandom_range(0, 12));
      send_item(mk(CMD_APPEND, TSEL_W'(t),
                   ($urandom_range(0, 6) == 0) ? pick_run() : r, b, pick_ps()));
    end
    k = $urandom_range(1, 4);
    repeat (k) begin
      b = ($urandom_range(0, 6) == 0) ? BLK_W'(b0 - 1) : BLK_W'(b0 + $urandom_range(0, 16));
      send_item(mk(CMD_QUERY, TSEL_W'(t), r, b, pick_ps()));
    end
  endtask

  task automatic random_phase(int count);
    int target;
    target = sent_count + count;
    while (sent_count < target) begin
      if ($urandom_range(0, 39) == 0) drain();
      if ($urandom_range(0, 4) < 3) send_chain();
      else send_item(random_item());
    end
  endtask

  initial begin
    // Hold reset, then release on an edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Lookup off after reset: a stored match still returns one
    send_item(mk(CMD_APPEND, 3'd0, 20'd7, 16'd3, 24'd77));
    send_item(mk(CMD_QUERY, 3'd0, 20'd7, 16'd3, '0));
    drain();
    set_lookup(1'b1);
    send_item(mk(CMD_QUERY, 3'd0, 20'd7, 16'd3, '0));
    send_item(mk(CMD_CLEAR, 3'd0, '0, '0, '0));

    // Field extremes, zero prescale and an empty table
    send_item(mk(CMD_QUERY, 3'd0, '0, '0, '0));
    send_item(mk(CMD_APPEND, 3'd0, '1, '0, '1));
    send_item(mk(CMD_APPEND, 3'd0, '0, '1, '0));
    send_item(mk(CMD_QUERY, 3'd0, '1, '1, '0));
    send_item(mk(CMD_QUERY, 3'd0, '0, '1, '0));
    send_item(mk(CMD_QUERY, 3'd0, '0, 16'hFFFE, '0));

    // Advance past the first match, including a lower start after a higher one
    send_item(mk(CMD_APPEND, 3'd1, 20'd5, 16'd10, 24'd100));
    send_item(mk(CMD_APPEND, 3'd1, 20'd5, 16'd20, 24'd200));
    send_item(mk(CMD_APPEND, 3'd1, 20'd5, 16'd30, 24'd300));
    send_item(mk(CMD_APPEND, 3'd1, 20'd5, 16'd15, 24'd150));
    send_item(mk(CMD_QUERY, 3'd1, 20'd5, 16'd25, '0));
    send_item(mk(CMD_QUERY, 3'd1, 20'd5, 16'd40, '0));
    send_item(mk(CMD_QUERY, 3'd1, 20'd5, 16'd9, '0));

    // Unknown tables, the unused command, then clear and query again
    send_item(mk(CMD_APPEND, 3'd5, 20'd5, 16'd1, 24'd9));
    send_item(mk(CMD_APPEND, 3'd7, 20'd5, 16'd1, 24'd9));
    send_item(mk(CMD_QUERY, 3'd7, 20'd5, 16'd1, '0));
    send_item(mk(CMD_CLEAR, 3'd6, '0, '0, '0));
    send_item(mk(CMD_SPARE, 3'd1, 20'd5, 16'd25, '1));
    send_item(mk(CMD_QUERY, 3'd1, 20'd5, 16'd25, '0));
    send_item(mk(CMD_CLEAR, 3'd1, '0, '0, '0));
    send_item(mk(CMD_QUERY, 3'd1, 20'd5, 16'd25, '0));
    send_item(mk(CMD_APPEND, 3'(TABLE_COUNT - 1), 20'd1, 16'd1, 24'd2));
    send_item(mk(CMD_QUERY, 3'(TABLE_COUNT - 1), 20'd1, 16'd1, '0));

    random_phase(50);

    // Lookup off for a stretch of ordinary traffic
    drain();
    set_lookup(1'b0);
    random_phase(20);

    // Lookup back on; fill one table to the brim and overflow it
    drain();
    set_lookup(1'b1);
    send_item(mk(CMD_CLEAR, 3'(FULL_TABLE), '0, '0, '0));
    repeat (TABLE_DEPTH)
      send_item(mk(CMD_APPEND, 3'(FULL_TABLE), pick_run(), pick_blk(), pick_ps()));
    repeat (2)
      send_item(mk(CMD_APPEND, 3'(FULL_TABLE), pick_run(), pick_blk(), pick_ps()));
    repeat (4)
      send_item(mk(CMD_QUERY, 3'(FULL_TABLE), pick_run(), pick_blk(), '0));
    send_item(mk(CMD_QUERY, 3'(FULL_TABLE), 20'd12345, 16'd0, '0));
    send_item(mk(CMD_CLEAR, 3'(FULL_TABLE), '0, '0, '0));
    random_phase(40);

    // Let the last scans finish, then account for anything still owed
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (ledger.pending.size() != 0)
      ledger.report_mismatch($sformatf("%0d results never arrived", ledger.pending.size()));
    $display("Run covered %0d appends (%0d dropped) and %0d queries (%0d matched)",
             ledger.appends, ledger.drops, ledger.queries, ledger.hits);
    $display("with lookup on and off; %0d results checked, %0d mismatches",
             ledger.results, ledger.errors);
    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
